>>> rtl/core/mips_integer_execute_unit_assert.svh
// assertion macros for the integer execute unit
`ifndef MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MIEU_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define MIEU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> rtl/core/mieu_pkg.sv
// ----------------------------------------------------------------------------
// mieu_pkg
// shared types and constants of the integer execute unit
// ----------------------------------------------------------------------------
package mieu_pkg;
  localparam int unsigned DataWords = 4096;
  localparam int unsigned DwAw = $clog2(DataWords);
  localparam logic [31:0] GpReset = 32'h0050_0000;
  localparam logic [31:0] SpReset = 32'h005F_FFFC;

  localparam logic [2:0] StOk    = 3'd0;
  localparam logic [2:0] StTrap  = 3'd1;
  localparam logic [2:0] StOvf   = 3'd2;
  localparam logic [2:0] StUnk   = 3'd3;
  localparam logic [2:0] StAlign = 3'd4;
  localparam logic [2:0] StHalt  = 3'd5;

  localparam logic [0:0] RegGp = 1'd0;
  localparam logic [0:0] RegSp = 1'd1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;   // write zero at the clear index
    logic latch_instr;  // capture instruction and operands
    logic mem_read;     // fetch data word
    logic exec;         // finish an instruction and write its result
    logic mul_step;     // one multiply partial product step
    logic div_start;
    logic div_step;
    logic out_clear;    // result taken
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_mul;
    logic is_div;
    logic mul_last;
    logic div_last;
  } sts_t;
endpackage

>>> rtl/core/mips_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_integer_execute_unit
// integer execute core with apb configuration of gp and sp start values
// ----------------------------------------------------------------------------
// After reset the core sweeps its 4096-word data memory to zero, one word a
// cycle, and accepts no instruction until the sweep is done. An instruction
// then goes through operand read, memory read and execute to its result;
// mult and multu also pass through the shared 32x16 multiplier, and div and
// divu with a nonzero divisor through the one-bit-per-cycle divider.
// The next instruction is taken in the cycle its result transfer completes.
module mips_integer_execute_unit import mieu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        instr_valid_i,
  output logic        instr_ready_o,
  input  logic [31:0] instr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_pc_o,
  output logic [2:0]  status_o,
  output logic [4:0]  dest_reg_o,
  output logic [31:0] dest_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cmd_t cmd;
  sts_t sts;
  logic cfg_we;
  logic [31:0] gp, sp;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegSp) ? sp : gp;

  mieu_ctrl u_ctrl (
    .clk_i, .rst_ni, .instr_valid_i, .instr_ready_o, .out_valid_o,
    .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  mieu_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .instr_i,
    .cfg_we_i(cfg_we),
    .cfg_idx_i(paddr[2]), .cfg_data_i(pwdata), .gp_o(gp), .sp_o(sp),
    .next_pc_o, .status_o, .dest_reg_o, .dest_value_o
  );
endmodule

>>> rtl/core/mieu_ctrl.sv
// ----------------------------------------------------------------------------
// mieu_ctrl
// sequencer: memory clear after reset, fetch, execute, multi cycle ops
// ----------------------------------------------------------------------------
`include "mips_integer_execute_unit_assert.svh"
module mieu_ctrl import mieu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic instr_valid_i,
  output logic instr_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign instr_ready_o = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (instr_valid_i) begin
          cmd_o.latch_instr = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mem_read = 1'b1;
        if (sts_i.is_mul) begin
          state_d = S_MUL;
        end else if (sts_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_OUT;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          state_d = S_EXEC;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_EXEC;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          cmd_o.out_clear = 1'b1;
          if (instr_valid_i) begin
            cmd_o.latch_instr = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `MIEU_ASSERT_IMP(a_one_hot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `MIEU_ASSERT_NEXT(a_exec_out, clk_i, rst_ni, state_q == S_EXEC, out_valid_o)
  `MIEU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

>>> rtl/core/mieu_dpath.sv
// ----------------------------------------------------------------------------
// mieu_dpath
// register file, hi and lo, pc, data memory, alu, multiply and divide units
// ----------------------------------------------------------------------------
module mieu_dpath import mieu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [31:0] instr_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic [31:0] gp_o,
  output logic [31:0] sp_o,
  output logic [31:0] next_pc_o,
  output logic [2:0]  status_o,
  output logic [4:0]  dest_reg_o,
  output logic [31:0] dest_value_o
);
  logic [31:0] rf_q [32];
  logic [31:0] mem [DataWords];
  logic [31:0] gp_q, sp_q, hi_q, lo_q, pc_q;
  logic        halted_q;
  logic [DwAw-1:0] clr_q;
  logic [31:0] ir_q, a_q, b_q, mw_q;

  // multiply: 2 steps of 32x16
  logic [63:0] macc_q;
  logic        mstep_q;
  logic [31:0] mua, mub;
  // divide: restoring, one bit a step
  logic [31:0] dq_q, dr_q, dd_q;
  logic [5:0]  dcnt_q;
  logic        dna_q, dnb_q;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] imm, simm, addr, pc4, btgt;

  assign op = ir_q[31:26];
  assign rs = ir_q[25:21];
  assign rt = ir_q[20:16];
  assign rd = ir_q[15:11];
  assign sh = ir_q[10:6];
  assign fn = ir_q[5:0];
  assign imm = {16'd0, ir_q[15:0]};
  assign simm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign addr = a_q + simm;
  assign pc4 = pc_q + 32'd4;
  assign btgt = pc4 + {simm[29:0], 2'b00};

  logic is_mul, is_div;
  assign is_mul = (op == 6'd0) && (fn == 6'd24 || fn == 6'd25);
  assign is_div = (op == 6'd0) && (fn == 6'd26 || fn == 6'd27);

  assign sts_o.clear_last = (clr_q == DwAw'(DataWords - 1));
  assign sts_o.is_mul = is_mul && !halted_q && ir_q != 32'd0;
  assign sts_o.is_div = is_div && !halted_q && ir_q != 32'd0 && b_q != 32'd0;
  assign sts_o.mul_last = mstep_q;
  assign sts_o.div_last = (dcnt_q == 6'd0);

  assign gp_o = gp_q;
  assign sp_o = sp_q;

  // operand magnitude for multiply
  always_comb begin
    mua = (fn == 6'd24 && a_q[31]) ? 32'd0 - a_q : a_q;
    mub = (fn == 6'd24 && b_q[31]) ? 32'd0 - b_q : b_q;
  end

  logic [47:0] pp;
  assign pp = mua * (mstep_q ? mub[31:16] : mub[15:0]);

  logic [32:0] dtry;
  assign dtry = {dr_q, dd_q[31]} - {1'b0, dq_q};

  logic [DwAw-1:0] widx;
  logic [1:0] lane;
  assign widx = addr[DwAw+1:2];
  assign lane = addr[1:0];

  logic [2:0]  st_w;
  logic        wr_st;
  logic [31:0] st_word, wv, npc, nhi, nlo;
  logic [4:0]  wr;
  logic [7:0]  byt;
  logic [15:0] hw;
  logic        slt_s, slt_si;
  logic [63:0] mres;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      mem[clr_q] <= 32'd0;
    end else if (cmd_i.exec && st_w == StOk && wr_st) begin
      mem[widx] <= st_word;
    end
    if (cmd_i.mem_read) begin
      mw_q <= mem[widx];
    end
  end

  assign slt_s = $signed(a_q) < $signed(b_q);
  assign slt_si = $signed(a_q) < $signed(simm);
  assign mres = (fn == 6'd24 && (a_q[31] ^ b_q[31])) ? 64'd0 - macc_q : macc_q;

  always_comb begin
    st_w = StOk;
    wr = 5'd0;
    wv = 32'd0;
    npc = pc4;
    nhi = hi_q;
    nlo = lo_q;
    wr_st = 1'b0;
    st_word = mw_q;
    byt = 8'd0;
    hw = 16'd0;
    case (lane)
      2'd0: byt = mw_q[31:24];
      2'd1: byt = mw_q[23:16];
      2'd2: byt = mw_q[15:8];
      default: byt = mw_q[7:0];
    endcase
    hw = lane[1] ? mw_q[15:0] : mw_q[31:16];
    case (op)
      6'd0: begin
        case (fn)
          6'd0: begin wr = rd; wv = b_q << sh; end
          6'd2: begin wr = rd; wv = b_q >> sh; end
          6'd3: begin wr = rd; wv = 32'($signed(b_q) >>> sh); end
          6'd4: begin wr = rd; wv = b_q << a_q[4:0]; end
          6'd6: begin wr = rd; wv = b_q >> a_q[4:0]; end
          6'd7: begin wr = rd; wv = 32'($signed(b_q) >>> a_q[4:0]); end
          6'd8: npc = a_q;
          6'd9: begin wr = rd; wv = pc4; npc = a_q; end
          6'd16: begin wr = rd; wv = hi_q; end
          6'd17: nhi = a_q;
          6'd18: begin wr = rd; wv = lo_q; end
          6'd19: nlo = a_q;
          6'd24, 6'd25: begin nhi = mres[63:32]; nlo = mres[31:0]; end
          6'd26: begin
            if (b_q != 32'd0) begin
              nlo = (dna_q != dnb_q) ? 32'd0 - dd_q : dd_q;
              nhi = dna_q ? 32'd0 - dr_q : dr_q;
            end
          end
          6'd27: begin
            if (b_q != 32'd0) begin nlo = dd_q; nhi = dr_q; end
          end
          6'd32: begin
            wr = rd; wv = a_q + b_q;
            if (~(a_q[31] ^ b_q[31]) & (a_q[31] ^ wv[31])) st_w = StOvf;
          end
          6'd33: begin wr = rd; wv = a_q + b_q; end
          6'd34: begin
            wr = rd; wv = a_q - b_q;
            if ((a_q[31] ^ b_q[31]) & (a_q[31] ^ wv[31])) st_w = StOvf;
          end
          6'd35: begin wr = rd; wv = a_q - b_q; end
          6'd36: begin wr = rd; wv = a_q & b_q; end
          6'd37: begin wr = rd; wv = a_q | b_q; end
          6'd38: begin wr = rd; wv = a_q ^ b_q; end
          6'd39: begin wr = rd; wv = ~(a_q | b_q); end
          6'd42: begin wr = rd; wv = {31'd0, slt_s}; end
          6'd43: begin wr = rd; wv = {31'd0, a_q < b_q}; end
          6'd48: if (!slt_s) st_w = StTrap;
          6'd49: if (a_q >= b_q) st_w = StTrap;
          6'd50: if (slt_s) st_w = StTrap;
          6'd51: if (a_q < b_q) st_w = StTrap;
          6'd52: if (a_q == b_q) st_w = StTrap;
          6'd54: if (a_q != b_q) st_w = StTrap;
          default: st_w = StUnk;
        endcase
      end
      6'd1: begin
        case (rt)
          5'd0: if (a_q[31]) npc = btgt;
          5'd1: if (!a_q[31]) npc = btgt;
          5'd8: if (!slt_si) st_w = StTrap;
          5'd9: if (a_q >= simm) st_w = StTrap;
          5'd10: if (slt_si) st_w = StTrap;
          5'd11: if (a_q < simm) st_w = StTrap;
          5'd12: if (a_q == simm) st_w = StTrap;
          5'd14: if (a_q != simm) st_w = StTrap;
          5'd16: begin wr = 5'd31; wv = pc4; if (a_q[31]) npc = btgt; end
          5'd17: begin wr = 5'd31; wv = pc4; if (!a_q[31]) npc = btgt; end
          default: st_w = StUnk;
        endcase
      end
      6'd2: npc = {pc4[31:28], ir_q[25:0], 2'b00};
      6'd3: begin wr = 5'd31; wv = pc4; npc = {pc4[31:28], ir_q[25:0], 2'b00}; end
      6'd4: if (a_q == b_q) npc = btgt;
      6'd5: if (a_q != b_q) npc = btgt;
      6'd6: if (a_q == 32'd0 || a_q[31]) npc = btgt;
      6'd7: if (a_q != 32'd0 && !a_q[31]) npc = btgt;
      6'd8: begin
        wr = rt; wv = a_q + simm;
        if (~(a_q[31] ^ simm[31]) & (a_q[31] ^ wv[31])) st_w = StOvf;
      end
      6'd9: begin wr = rt; wv = a_q + simm; end
      6'd10: begin wr = rt; wv = {31'd0, slt_si}; end
      6'd11: begin wr = rt; wv = {31'd0, a_q < simm}; end
      6'd12: begin wr = rt; wv = a_q & imm; end
      6'd13: begin wr = rt; wv = a_q | imm; end
      6'd14: begin wr = rt; wv = a_q ^ imm; end
      6'd15: begin wr = rt; wv = {ir_q[15:0], 16'd0}; end
      6'd32: begin wr = rt; wv = {{24{byt[7]}}, byt}; end
      6'd36: begin wr = rt; wv = {24'd0, byt}; end
      6'd33: begin
        wr = rt; wv = {{16{hw[15]}}, hw};
        if (addr[0]) st_w = StAlign;
      end
      6'd37: begin
        wr = rt; wv = {16'd0, hw};
        if (addr[0]) st_w = StAlign;
      end
      6'd35, 6'd48: begin
        wr = rt; wv = mw_q;
        if (addr[1:0] != 2'd0) st_w = StAlign;
      end
      6'd40: begin
        wr_st = 1'b1;
        case (lane)
          2'd0: st_word[31:24] = b_q[7:0];
          2'd1: st_word[23:16] = b_q[7:0];
          2'd2: st_word[15:8] = b_q[7:0];
          default: st_word[7:0] = b_q[7:0];
        endcase
      end
      6'd41: begin
        wr_st = 1'b1;
        if (lane[1]) st_word[15:0] = b_q[15:0];
        else st_word[31:16] = b_q[15:0];
        if (addr[0]) st_w = StAlign;
      end
      6'd43, 6'd56: begin
        wr_st = 1'b1; st_word = b_q;
        if (op == 6'd56) begin wr = rt; wv = 32'd1; end
        if (addr[1:0] != 2'd0) st_w = StAlign;
      end
      default: st_w = StUnk;
    endcase
    if (halted_q || ir_q == 32'd0) begin
      st_w = StHalt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_instr) begin
      ir_q <= instr_i;
      a_q <= rf_q[instr_i[25:21]];
      b_q <= rf_q[instr_i[20:16]];
    end
    if (cmd_i.mem_read) begin
      macc_q <= 64'd0;
      dna_q <= fn == 6'd26 && a_q[31];
      dnb_q <= fn == 6'd26 && b_q[31];
    end
    if (cmd_i.mul_step) begin
      if (mstep_q) macc_q <= macc_q + {pp, 16'd0};
      else macc_q <= macc_q + {16'd0, pp};
    end
    if (cmd_i.div_start) begin
      dd_q <= (fn == 6'd26 && a_q[31]) ? 32'd0 - a_q : a_q;
      dq_q <= (fn == 6'd26 && b_q[31]) ? 32'd0 - b_q : b_q;
      dr_q <= 32'd0;
    end else if (cmd_i.div_step) begin
      if (!dtry[32]) begin
        dr_q <= dtry[31:0];
        dd_q <= {dd_q[30:0], 1'b1};
      end else begin
        dr_q <= {dr_q[30:0], dd_q[31]};
        dd_q <= {dd_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      mstep_q <= 1'b0;
      dcnt_q <= 6'd0;
      gp_q <= GpReset;
      sp_q <= SpReset;
      hi_q <= 32'd0;
      lo_q <= 32'd0;
      pc_q <= 32'd0;
      halted_q <= 1'b0;
      next_pc_o <= 32'd0;
      status_o <= StOk;
      dest_reg_o <= 5'd0;
      dest_value_o <= 32'd0;
      for (int i = 0; i < 32; i++) begin
        rf_q[i] <= 32'd0;
      end
      rf_q[28] <= GpReset;
      rf_q[29] <= SpReset;
      rf_q[30] <= SpReset;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + DwAw'(1);
      if (cmd_i.mul_step) mstep_q <= !mstep_q;
      if (cmd_i.div_start) dcnt_q <= 6'd31;
      else if (cmd_i.div_step && dcnt_q != 6'd0) dcnt_q <= dcnt_q - 6'd1;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegGp) begin
          gp_q <= cfg_data_i;
          rf_q[28] <= cfg_data_i;
        end else begin
          sp_q <= cfg_data_i;
          rf_q[29] <= cfg_data_i;
          rf_q[30] <= cfg_data_i;
        end
      end
      if (cmd_i.exec) begin
        next_pc_o <= pc_q;
        status_o <= st_w;
        dest_reg_o <= 5'd0;
        dest_value_o <= 32'd0;
        if (st_w != StOk) begin
          halted_q <= 1'b1;
        end else begin
          pc_q <= npc;
          next_pc_o <= npc;
          hi_q <= nhi;
          lo_q <= nlo;
          if (wr != 5'd0) begin
            rf_q[wr] <= wv;
            dest_reg_o <= wr;
            dest_value_o <= wv;
          end
        end
      end
    end
  end
endmodule
